// File: rtl/core/flc_pkg.sv
// Package with shared constants, register codes and helpers for the frequency-to-note block.
package flc_pkg;

    localparam int LOG_FRAC_BITS_DEF = 20;
    localparam int FREQ_W = 32;
    localparam int MANT_W = 32;
    localparam int EXP_W = 5;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NOTE_W = 7;
    localparam int CENTS_W = 15;
    localparam int PC_W = 4;
    localparam int OCT_W = 5;
    localparam int OUT_W = 32;

    localparam logic [CFG_W-1:0] REF_LOW = 16'd55040;
    localparam logic [CFG_W-1:0] REF_HIGH = 16'd57600;
    localparam logic [CFG_W-1:0] REF_RESET = 16'd56320;
    localparam logic [CFG_W-1:0] MIN_RESET = 16'd20;
    localparam logic [CFG_W-1:0] MAX_RESET = 16'd4200;

    localparam int NOTE_MAX = 127;
    localparam int NOTE_A4 = 69;
    localparam int UNIT_SHIFT = 9;
    localparam int CENTS_LIMIT = 12800;
    localparam int CENTS_SCALE = 25600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REFERENCE_PITCH = 2'd0,
        REG_MIN_FREQUENCY   = 2'd1,
        REG_MAX_FREQUENCY   = 2'd2
    } cfg_index_t;

    // Quotient by twelve through a reciprocal multiply, exact for 0..127.
    function automatic logic [3:0] div12(input logic [NOTE_W-1:0] n);
        logic [12:0] p;
        begin
            p = 13'(n) * 13'd43;
            div12 = p[12:9];
        end
    endfunction

endpackage

// File: rtl/core/flc_cell.sv
// One log2 refinement cell: squares both mantissas and emits one fraction bit of each.
module flc_cell
    import flc_pkg::*;
#(
    parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF,
    parameter int STEP = 0
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_pitched,
    input  logic [EXP_W-1:0]         in_exp_f,
    input  logic [MANT_W-1:0]        in_mant_f,
    input  logic [LOG_FRAC_BITS-1:0] in_frac_f,
    input  logic [EXP_W-1:0]         in_exp_r,
    input  logic [MANT_W-1:0]        in_mant_r,
    input  logic [LOG_FRAC_BITS-1:0] in_frac_r,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     out_pitched,
    output logic [EXP_W-1:0]         out_exp_f,
    output logic [MANT_W-1:0]        out_mant_f,
    output logic [LOG_FRAC_BITS-1:0] out_frac_f,
    output logic [EXP_W-1:0]         out_exp_r,
    output logic [MANT_W-1:0]        out_mant_r,
    output logic [LOG_FRAC_BITS-1:0] out_frac_r
);

    localparam int BIT_POS = LOG_FRAC_BITS - 1 - STEP;

    logic                     valid_reg;
    logic                     pitched_reg;
    logic [EXP_W-1:0]         exp_f_reg;
    logic [EXP_W-1:0]         exp_r_reg;
    logic [MANT_W-1:0]        mant_f_reg;
    logic [MANT_W-1:0]        mant_f_next;
    logic [MANT_W-1:0]        mant_r_reg;
    logic [MANT_W-1:0]        mant_r_next;
    logic [LOG_FRAC_BITS-1:0] frac_f_reg;
    logic [LOG_FRAC_BITS-1:0] frac_f_next;
    logic [LOG_FRAC_BITS-1:0] frac_r_reg;
    logic [LOG_FRAC_BITS-1:0] frac_r_next;
    logic [2*MANT_W-1:0]      sq_f;
    logic [2*MANT_W-1:0]      sq_r;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        sq_f = in_mant_f * in_mant_f;
        sq_r = in_mant_r * in_mant_r;
        frac_f_next = in_frac_f;
        frac_r_next = in_frac_r;
        if (sq_f[2*MANT_W-1])
        begin
            mant_f_next = sq_f[2*MANT_W-1:MANT_W];
            frac_f_next[BIT_POS] = 1'b1;
        end
        else
        begin
            mant_f_next = sq_f[2*MANT_W-2:MANT_W-1];
        end
        if (sq_r[2*MANT_W-1])
        begin
            mant_r_next = sq_r[2*MANT_W-1:MANT_W];
            frac_r_next[BIT_POS] = 1'b1;
        end
        else
        begin
            mant_r_next = sq_r[2*MANT_W-2:MANT_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pitched_reg <= in_pitched;
            exp_f_reg   <= in_exp_f;
            exp_r_reg   <= in_exp_r;
            mant_f_reg  <= mant_f_next;
            mant_r_reg  <= mant_r_next;
            frac_f_reg  <= frac_f_next;
            frac_r_reg  <= frac_r_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_pitched = pitched_reg;
    assign out_exp_f   = exp_f_reg;
    assign out_mant_f  = mant_f_reg;
    assign out_frac_f  = frac_f_reg;
    assign out_exp_r   = exp_r_reg;
    assign out_mant_r  = mant_r_reg;
    assign out_frac_r  = frac_r_reg;

endmodule

// File: rtl/core/flc_post.sv
// Note, cents, pitch class and octave from the two logarithms, in two stages.
module flc_post
    import flc_pkg::*;
#(
    parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_pitched,
    input  logic [EXP_W-1:0]         in_exp_f,
    input  logic [LOG_FRAC_BITS-1:0] in_frac_f,
    input  logic [EXP_W-1:0]         in_exp_r,
    input  logic [LOG_FRAC_BITS-1:0] in_frac_r,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [OUT_W-1:0]         out_data
);

    localparam int L = LOG_FRAC_BITS;
    localparam int XW = L + 10;
    localparam int PW = XW + 16;
    localparam logic signed [XW-1:0] X_HALF = XW'(1) <<< (L - 1);
    localparam logic signed [XW-1:0] X_BIAS = XW'(NOTE_A4) <<< L;
    localparam logic signed [PW-1:0] P_HALF = PW'(1) <<< (L - 1);
    localparam logic signed [PW-1:0] P_LIMIT = PW'(CENTS_LIMIT);
    localparam logic signed [15:0] SCALE = 16'(CENTS_SCALE);

    logic                    a_valid_reg;
    logic                    a_ready;
    logic                    a_pitched_reg;
    logic signed [XW-1:0]    a_x_reg;
    logic [NOTE_W-1:0]       a_note_reg;
    logic [NOTE_W-1:0]       a_note_next;
    logic signed [6:0]       int_part;
    logic signed [XW-1:0]    d_val;
    logic signed [XW-1:0]    x_val;
    logic signed [XW-1:0]    rnd;

    logic                    b_valid_reg;
    logic [OUT_W-1:0]        b_data_reg;
    logic [OUT_W-1:0]        b_data_next;
    logic signed [XW-1:0]    err;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    cs;
    logic signed [CENTS_W-1:0] cents;
    logic [3:0]              quo;
    logic [PC_W-1:0]         pc;
    logic [OCT_W-1:0]        oct;

    assign a_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || a_ready;

    always_comb
    begin
        int_part = $signed({2'b00, in_exp_f}) - $signed({2'b00, in_exp_r})
                   - 7'sd9;
        d_val = $signed({{(XW-7-L){int_part[6]}}, int_part, {L{1'b0}}})
                + $signed({{(XW-L){1'b0}}, in_frac_f})
                - $signed({{(XW-L){1'b0}}, in_frac_r});
        x_val = (d_val <<< 3) + (d_val <<< 2) + X_BIAS;
        rnd = (x_val + X_HALF) >>> L;
        if (rnd < 0)
        begin
            a_note_next = '0;
        end
        else if (rnd > XW'(NOTE_MAX))
        begin
            a_note_next = NOTE_W'(NOTE_MAX);
        end
        else
        begin
            a_note_next = rnd[NOTE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (a_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_pitched_reg <= in_pitched;
            a_x_reg       <= x_val;
            a_note_reg    <= a_note_next;
        end
        if (a_ready && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    always_comb
    begin
        err = a_x_reg - $signed({{(XW-L-NOTE_W){1'b0}}, a_note_reg, {L{1'b0}}});
        prod = PW'(err) * PW'(SCALE);
        cs = (prod + P_HALF) >>> L;
        if (cs > P_LIMIT)
        begin
            cents = CENTS_W'(CENTS_LIMIT);
        end
        else if (cs < -P_LIMIT)
        begin
            cents = -CENTS_W'(CENTS_LIMIT);
        end
        else
        begin
            cents = cs[CENTS_W-1:0];
        end
        quo = div12(a_note_reg);
        pc = PC_W'(a_note_reg - (NOTE_W'(quo) * NOTE_W'(12)));
        oct = OCT_W'(quo) - OCT_W'(1);
        if (a_pitched_reg)
        begin
            b_data_next = {oct, pc, cents, a_note_reg, 1'b1};
        end
        else
        begin
            b_data_next = '0;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

// File: rtl/core/frequency_to_note_and_cents.sv
// Top level: frequency in, MIDI note and cents offset out, through a row of log2 cells.
//
// Channel   Direction  Payload
// s_axis    in         tdata[31:0] frequency, UQ16.16 Hz
// m_axis    out        tdata: pitched, note_num, cent_dev, pitch_class, octave
// cfg       in         cfg_index selects register, cfg_data is written; reference only in REF_LOW..REF_HIGH
//
// One request per cycle is accepted while m_axis is not stalled. Requests pass
// through the input register, one squaring cell per fraction bit and flc_post.
// Each stage holds its request when the next one is full, so a stall on
// m_axis backs up stage by stage. Reset restores the default registers.
module frequency_to_note_and_cents
    import flc_pkg::*;
#(
    parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [FREQ_W-1:0]    s_axis_tdata,  // [31:0] frequency
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] pitched, [7:1] note_num, [22:8] cent_dev, [26:23] pitch_class,
    // [31:27] octave
    output logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 cfg_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int L = LOG_FRAC_BITS;

    logic [CFG_W-1:0] ref_reg;
    logic [CFG_W-1:0] min_reg;
    logic [CFG_W-1:0] max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= REF_RESET;
            min_reg <= MIN_RESET;
            max_reg <= MAX_RESET;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                REG_REFERENCE_PITCH:
                begin
                    if (cfg_data >= REF_LOW && cfg_data <= REF_HIGH)
                    begin
                        ref_reg <= cfg_data;
                    end
                end
                REG_MIN_FREQUENCY: min_reg <= cfg_data;
                REG_MAX_FREQUENCY: max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [EXP_W-1:0]  exp_f;
    logic [EXP_W-1:0]  exp_r;
    logic              pitched;
    logic              pre_valid_reg;
    logic              pre_ready;
    logic              pre_pitched_reg;
    logic [EXP_W-1:0]  pre_exp_f_reg;
    logic [EXP_W-1:0]  pre_exp_r_reg;
    logic [MANT_W-1:0] pre_mant_f_reg;
    logic [MANT_W-1:0] pre_mant_r_reg;

    always_comb
    begin
        exp_f = '0;
        exp_r = '0;
        for (int i = 0; i < FREQ_W; i++)
        begin
            if (s_axis_tdata[i])
            begin
                exp_f = EXP_W'(i);
            end
        end
        for (int i = 0; i < CFG_W; i++)
        begin
            if (ref_reg[i])
            begin
                exp_r = EXP_W'(i);
            end
        end
        pitched = (s_axis_tdata > {min_reg, 16'h0000})
                  && (s_axis_tdata < {max_reg, 16'h0000});
    end

    logic             c_valid   [0:L];
    logic             c_ready   [0:L];
    logic             c_pitched [0:L];
    logic [EXP_W-1:0] c_exp_f   [0:L];
    logic [EXP_W-1:0] c_exp_r   [0:L];
    logic [MANT_W-1:0] c_mant_f [0:L];
    logic [MANT_W-1:0] c_mant_r [0:L];
    logic [L-1:0]     c_frac_f  [0:L];
    logic [L-1:0]     c_frac_r  [0:L];

    assign s_axis_tready = !pre_valid_reg || c_ready[0];
    assign pre_ready = s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (pre_ready)
        begin
            pre_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pre_ready && s_axis_tvalid)
        begin
            pre_pitched_reg <= pitched;
            pre_exp_f_reg   <= exp_f;
            pre_exp_r_reg   <= exp_r;
            pre_mant_f_reg  <= s_axis_tdata << (5'd31 - exp_f);
            pre_mant_r_reg  <= {ref_reg, 16'h0000} << (5'd15 - exp_r);
        end
    end

    assign c_valid[0]   = pre_valid_reg;
    assign c_pitched[0] = pre_pitched_reg;
    assign c_exp_f[0]   = pre_exp_f_reg;
    assign c_exp_r[0]   = pre_exp_r_reg;
    assign c_mant_f[0]  = pre_mant_f_reg;
    assign c_mant_r[0]  = pre_mant_r_reg;
    assign c_frac_f[0]  = '0;
    assign c_frac_r[0]  = '0;

    for (genvar k = 0; k < L; k++)
    begin : g_cell
        flc_cell #(
            .LOG_FRAC_BITS(L),
            .STEP(k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (c_valid[k]),
            .in_ready   (c_ready[k]),
            .in_pitched (c_pitched[k]),
            .in_exp_f   (c_exp_f[k]),
            .in_mant_f  (c_mant_f[k]),
            .in_frac_f  (c_frac_f[k]),
            .in_exp_r   (c_exp_r[k]),
            .in_mant_r  (c_mant_r[k]),
            .in_frac_r  (c_frac_r[k]),
            .out_valid  (c_valid[k+1]),
            .out_ready  (c_ready[k+1]),
            .out_pitched(c_pitched[k+1]),
            .out_exp_f  (c_exp_f[k+1]),
            .out_mant_f (c_mant_f[k+1]),
            .out_frac_f (c_frac_f[k+1]),
            .out_exp_r  (c_exp_r[k+1]),
            .out_mant_r (c_mant_r[k+1]),
            .out_frac_r (c_frac_r[k+1])
        );
    end

    flc_post #(
        .LOG_FRAC_BITS(L)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid[L]),
        .in_ready  (c_ready[L]),
        .in_pitched(c_pitched[L]),
        .in_exp_f  (c_exp_f[L]),
        .in_frac_f (c_frac_f[L]),
        .in_exp_r  (c_exp_r[L]),
        .in_frac_r (c_frac_r[L]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
